// File: rtl/ksa_pkg.sv
// Shared types and constants for the keyed sum accumulator.
// Used by ksa_front, ksa_back and keyed_sum_accumulator; no dependencies.
package ksa_pkg;

    localparam int KEY_W = 16;
    localparam int AMT_W = 8;
    localparam int TOT_W = 24;
    localparam int ST_W  = 2;

    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    localparam logic [ST_W-1:0] ST_DATA  = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_IW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic             is_read;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amount;
    } t_cmd;

endpackage

// File: rtl/keyed_sum_accumulator.sv
// Top level of the keyed sum accumulator: command queue front end and table back end.
// Depends on ksa_pkg, ksa_front and ksa_back.
//
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_stall  | i_opcode, i_key, i_amount
//   result  | out       | o_valid / i_stall  | o_status, o_entry_key, o_entry_total, o_last
//
// An add reads and compares the stored entries in turn, then updates a match, inserts, or is dropped when full.
// A readout reads and emits each entry in turn, from the last stored entry down to the first;
// an empty readout emits a single empty-status result.
// The entry memories have a single read port; each entry is read before its compare or emit.
// Reset empties the table by clearing the entry count; the entry memories are not cleared.
// A stalled result holds the back end's emits; the front queue keeps taking up to two transfers.
module keyed_sum_accumulator #(
    parameter int ENTRIES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_opcode,
    input  logic [ksa_pkg::KEY_W-1:0] i_key,
    input  logic [ksa_pkg::AMT_W-1:0] i_amount,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ksa_pkg::ST_W-1:0]  o_status,
    output logic [ksa_pkg::KEY_W-1:0] o_entry_key,
    output logic [ksa_pkg::TOT_W-1:0] o_entry_total,
    output logic                      o_last
);

    logic          q_valid;
    ksa_pkg::t_cmd q_cmd;
    logic          q_pop;

    ksa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_opcode  (i_opcode),
        .i_key     (i_key),
        .i_amount  (i_amount),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    ksa_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_entry_key   (o_entry_key),
        .o_entry_total (o_entry_total),
        .o_last        (o_last)
    );

endmodule

// File: rtl/ksa_front.sv
// Front end: accepts input transfers, classifies them and queues commands.
// Depends on ksa_pkg.
module ksa_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_opcode,
    input  logic [ksa_pkg::KEY_W-1:0] i_key,
    input  logic [ksa_pkg::AMT_W-1:0] i_amount,
    output logic                     o_q_valid,
    output ksa_pkg::t_cmd            o_q_cmd,
    input  logic                     i_q_pop
);

    ksa_pkg::t_cmd                 r_q [ksa_pkg::Q_DEPTH];
    logic [ksa_pkg::Q_IW-1:0]      r_wp;
    logic [ksa_pkg::Q_IW-1:0]      r_rp;
    logic [ksa_pkg::Q_CW-1:0]      r_cnt;
    logic [ksa_pkg::Q_IW-1:0]      n_wp;
    logic [ksa_pkg::Q_IW-1:0]      n_rp;
    logic [ksa_pkg::Q_CW-1:0]      n_cnt;
    logic                          push;
    logic                          pop;
    ksa_pkg::t_cmd                 cmd_in;

    assign o_stall   = (r_cnt == ksa_pkg::Q_CW'(ksa_pkg::Q_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_q[r_rp];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        cmd_in.is_read = (i_opcode == ksa_pkg::OP_READ);
        cmd_in.key     = i_key;
        cmd_in.amount  = i_amount;
    end

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        unique case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// File: rtl/ksa_back.sv
// Back end: entry memories, scan sequencer and registered result output.
// Depends on ksa_pkg; takes commands from ksa_front.
module ksa_back #(
    parameter int ENTRIES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  ksa_pkg::t_cmd             i_q_cmd,
    output logic                      o_q_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ksa_pkg::ST_W-1:0]  o_status,
    output logic [ksa_pkg::KEY_W-1:0] o_entry_key,
    output logic [ksa_pkg::TOT_W-1:0] o_entry_total,
    output logic                      o_last
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_AREAD  = 3'd1;
    localparam logic [2:0] S_ACMP   = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_RREAD  = 3'd4;
    localparam logic [2:0] S_REMIT  = 3'd5;
    localparam logic [2:0] S_SINGLE = 3'd6;

    logic [ksa_pkg::KEY_W-1:0] r_keys [ENTRIES];
    logic [ksa_pkg::TOT_W-1:0] r_tots [ENTRIES];

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [IW-1:0]             r_idx;
    logic [IW-1:0]             n_idx;
    ksa_pkg::t_cmd             r_cmd;
    ksa_pkg::t_cmd             n_cmd;
    logic [ksa_pkg::ST_W-1:0]  r_single;
    logic [ksa_pkg::ST_W-1:0]  n_single;
    logic [ksa_pkg::KEY_W-1:0] r_rd_key;
    logic [ksa_pkg::TOT_W-1:0] r_rd_tot;

    logic                      r_ovalid;
    logic [ksa_pkg::ST_W-1:0]  r_ostatus;
    logic [ksa_pkg::KEY_W-1:0] r_okey;
    logic [ksa_pkg::TOT_W-1:0] r_otot;
    logic                      r_olast;

    logic                      out_free;
    logic                      load_out;
    logic [ksa_pkg::ST_W-1:0]  out_st;
    logic [ksa_pkg::KEY_W-1:0] out_key;
    logic [ksa_pkg::TOT_W-1:0] out_tot;
    logic                      out_last;

    logic                      wr_key_en;
    logic                      wr_tot_en;
    logic [IW-1:0]             wr_addr;
    logic [ksa_pkg::TOT_W-1:0] wr_tot;
    logic [ksa_pkg::TOT_W:0]   sum;
    logic [ksa_pkg::TOT_W-1:0] sat_sum;
    logic [CW-1:0]             last_idx;
    logic                      at_last;

    assign out_free = !r_ovalid || !i_stall;
    assign sum      = {1'b0, r_rd_tot} + (ksa_pkg::TOT_W + 1)'(r_cmd.amount);
    assign sat_sum  = sum[ksa_pkg::TOT_W] ? ksa_pkg::TOT_MAX : sum[ksa_pkg::TOT_W-1:0];
    assign last_idx = r_count - 1'b1;
    assign at_last  = (CW'(r_idx) == last_idx);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_single  = r_single;
        o_q_pop   = 1'b0;
        wr_key_en = 1'b0;
        wr_tot_en = 1'b0;
        wr_addr   = r_idx;
        wr_tot    = sat_sum;
        load_out  = 1'b0;
        out_st    = ksa_pkg::ST_DATA;
        out_key   = r_rd_key;
        out_tot   = r_rd_tot;
        out_last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    if (i_q_cmd.is_read) begin
                        if (r_count == '0) begin
                            n_single = ksa_pkg::ST_EMPTY;
                            n_state  = S_SINGLE;
                        end else begin
                            n_idx   = last_idx[IW-1:0];
                            n_state = S_RREAD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_state = S_INSERT;
                        end else begin
                            n_idx   = '0;
                            n_state = S_AREAD;
                        end
                    end
                end
            end
            S_AREAD: begin
                n_state = S_ACMP;
            end
            S_ACMP: begin
                priority if (r_rd_key == r_cmd.key) begin
                    wr_tot_en = 1'b1;
                    wr_addr   = r_idx;
                    wr_tot    = sat_sum;
                    n_state   = S_IDLE;
                end else if (at_last) begin
                    if (r_count == CW'(ENTRIES)) begin
                        n_single = ksa_pkg::ST_FULL;
                        n_state  = S_SINGLE;
                    end else begin
                        n_state = S_INSERT;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_AREAD;
                end
            end
            S_INSERT: begin
                wr_key_en = 1'b1;
                wr_tot_en = 1'b1;
                wr_addr   = r_count[IW-1:0];
                wr_tot    = ksa_pkg::TOT_W'(r_cmd.amount);
                n_count   = r_count + 1'b1;
                n_state   = S_IDLE;
            end
            S_RREAD: begin
                n_state = S_REMIT;
            end
            S_REMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_st   = ksa_pkg::ST_DATA;
                    out_key  = r_rd_key;
                    out_tot  = r_rd_tot;
                    out_last = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_RREAD;
                    end
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_st   = r_single;
                    out_key  = (r_single == ksa_pkg::ST_FULL) ? r_cmd.key : '0;
                    out_tot  = '0;
                    out_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cmd    <= n_cmd;
        r_single <= n_single;
        if (load_out) begin
            r_ostatus <= out_st;
            r_okey    <= out_key;
            r_otot    <= out_tot;
            r_olast   <= out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key <= r_keys[r_idx];
        r_rd_tot <= r_tots[r_idx];
        if (wr_key_en) begin
            r_keys[wr_addr] <= r_cmd.key;
        end
        if (wr_tot_en) begin
            r_tots[wr_addr] <= wr_tot;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_entry_key   = r_okey;
    assign o_entry_total = r_otot;
    assign o_last        = r_olast;

endmodule
